/* hdl/kr_pkg.sv */
// Shared constants and types for the keyed slot registry.
`default_nettype none
package kr_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int KEY_W       = 16;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 3;
  localparam int COUNT_W     = 4;
  // index width that covers the largest supported table (64 entries)
  localparam int IDX_W       = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd2;
  localparam logic [OP_W-1:0] OP_FINDLOCAL = 3'd3;
  localparam logic [OP_W-1:0] OP_RESETALL  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Search token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic             act;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic             loc;
    logic             m_hit;
    logic [IDX_W-1:0] m_idx;
    logic             m_loc;
    logic             f_hit;
    logic [IDX_W-1:0] f_idx;
    logic             l_hit;
    logic [IDX_W-1:0] l_idx;
    logic [KEY_W-1:0] l_key;
  } kr_token_t;

  // Write command broadcast to every cell.
  typedef struct packed {
    logic             clear_all;
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             loc;
  } kr_cmd_t;

endpackage
`default_nettype wire

/* hdl/kr_cell.sv */
// One registry entry: holds valid, key and local flag and updates the passing search token.
`default_nettype none
module kr_cell #(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kr_pkg::kr_token_t tok_in,
  input  wire kr_pkg::kr_cmd_t   cmd,
  output kr_pkg::kr_token_t      tok_out
);
  import kr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic             loc;
  kr_token_t        tok_next;

  always_comb begin
    tok_next = tok_in;
    if (valid && (key == tok_in.key) && !tok_in.m_hit) begin
      tok_next.m_hit = 1'b1;
      tok_next.m_idx = MY_IDX;
      tok_next.m_loc = loc;
    end
    if (!valid && !tok_in.f_hit) begin
      tok_next.f_hit = 1'b1;
      tok_next.f_idx = MY_IDX;
    end
    if (valid && loc && !tok_in.l_hit) begin
      tok_next.l_hit = 1'b1;
      tok_next.l_idx = MY_IDX;
      tok_next.l_key = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.act <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      valid <= 1'b0;
      key   <= '0;
      loc   <= 1'b0;
    end else if (cmd.wr && (cmd.wr_idx == MY_IDX)) begin
      valid <= cmd.valid;
      key   <= cmd.key;
      loc   <= cmd.loc;
    end
  end

endmodule
`default_nettype wire

/* hdl/keyed_slot_registry.sv */
// Top level of the keyed slot registry: request entry, cell chain and result register.
`default_nettype none
// A request is taken when start is high and busy is low. Its search token
// passes down a chain of ENTRIES cells, one cell per clock, collecting the
// lowest matching entry, the lowest free entry and the lowest local entry.
// When the token leaves the last cell the table write is committed and the
// result is registered, so done pulses for one cycle once the token has
// passed the head register and every cell. busy falls at the same edge,
// and a new request may be issued in the cycle that done is high. The
// receiver cannot stall: it must capture the result in the cycle that
// done is high.
module keyed_slot_registry #(
  parameter int ENTRIES = kr_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [kr_pkg::OP_W-1:0]       op,
  input  wire logic [kr_pkg::KEY_W-1:0]      player_id,
  input  wire logic                          is_local,
  output logic                               done,
  output logic [kr_pkg::STATUS_W-1:0]       status,
  output logic [kr_pkg::SLOT_W-1:0]         slot,
  output logic [kr_pkg::KEY_W-1:0]          entry_key,
  output logic                               entry_local,
  output logic                               newly_claimed,
  output logic [kr_pkg::COUNT_W-1:0]        live_count
);
  import kr_pkg::*;

  kr_token_t tok [0:ENTRIES];
  kr_token_t tail;
  kr_cmd_t   cmd;

  logic               accept;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;

  logic [STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]    idx_next;
  logic [KEY_W-1:0]    key_next;
  logic                local_next;
  logic                claimed_next;

  assign accept = start && !busy;
  assign tail   = tok[ENTRIES];

  // inject the request at the head of the chain for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].act <= 1'b0;
    end else begin
      tok[0].act <= accept;
      if (accept) begin
        tok[0].op    <= op;
        tok[0].key   <= player_id;
        tok[0].loc   <= is_local;
        tok[0].m_hit <= 1'b0;
        tok[0].m_idx <= '0;
        tok[0].m_loc <= 1'b0;
        tok[0].f_hit <= 1'b0;
        tok[0].f_idx <= '0;
        tok[0].l_hit <= 1'b0;
        tok[0].l_idx <= '0;
        tok[0].l_key <= '0;
      end
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kr_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .cmd    (cmd),
      .tok_out(tok[i+1])
    );
  end

  // decide the result and the table write when the token leaves the chain
  always_comb begin
    cmd           = '0;
    count_next    = count;
    status_next   = ST_NOTFOUND;
    idx_next      = '0;
    key_next      = '0;
    local_next    = 1'b0;
    claimed_next  = 1'b0;
    case (tail.op)
      OP_ADD: begin
        if (tail.m_hit || tail.f_hit) begin
          status_next = ST_OK;
          idx_next    = tail.m_hit ? tail.m_idx : tail.f_idx;
          key_next    = tail.key;
          local_next  = tail.loc;
          cmd.wr      = tail.act;
          cmd.wr_idx  = idx_next;
          cmd.valid   = 1'b1;
          cmd.key     = tail.key;
          cmd.loc     = tail.loc;
          if (!tail.m_hit) begin
            claimed_next = 1'b1;
            if (count != COUNT_MAX) begin
              count_next = count + 1'b1;
            end
          end
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (tail.m_hit) begin
          status_next = ST_OK;
          idx_next    = tail.m_idx;
          key_next    = tail.key;
          local_next  = tail.m_loc;
          cmd.wr      = tail.act;
          cmd.wr_idx  = tail.m_idx;
          if (count != '0) begin
            count_next = count - 1'b1;
          end
        end
      end
      OP_LOOKUP: begin
        if (tail.m_hit) begin
          status_next = ST_OK;
          idx_next    = tail.m_idx;
          key_next    = tail.key;
          local_next  = tail.m_loc;
        end
      end
      OP_FINDLOCAL: begin
        if (tail.l_hit) begin
          status_next = ST_OK;
          idx_next    = tail.l_idx;
          key_next    = tail.l_key;
          local_next  = 1'b1;
        end
      end
      OP_RESETALL: begin
        status_next   = ST_OK;
        cmd.clear_all = tail.act;
        count_next    = '0;
      end
      default: begin
        status_next = ST_NOTFOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= tail.act;
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.act) begin
        busy <= 1'b0;
      end
      if (tail.act) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.act) begin
      status        <= status_next;
      slot          <= idx_next[SLOT_W-1:0];
      entry_key     <= key_next;
      entry_local   <= local_next;
      newly_claimed <= claimed_next;
      live_count    <= count_next;
    end
  end

  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result issued with no request in flight");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after request taken");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("more than one result for a request");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((slot == '0) && (entry_key == '0) && !newly_claimed))
    else $error("failed request reports nonzero fields");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (ENTRIES < 16) |-> (count <= COUNT_W'(ENTRIES)))
    else $error("live count exceeds table size");

endmodule
`default_nettype wire
